@@ hw/rtl/aidp_pkg.sv @@
// ----------------------------------------------------------------------------
// aidp_pkg - shared types for the positional word table
// Op codes, status codes, per-cell update actions and the control struct
// passed from the decoder to the top level.
// ----------------------------------------------------------------------------
package aidp_pkg;

  localparam int CAPACITY_DEF = 8;
  localparam int WORD_W       = 32;
  localparam int OP_W         = 3;
  localparam int POS_W        = 4;
  localparam int OCC_W        = 4;

  typedef enum logic [OP_W-1:0] {
    OP_INS_ORD = 3'd0,
    OP_DEL_ORD = 3'd1,
    OP_INS_UN  = 3'd2,
    OP_DEL_UN  = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // What every cell does with its entry this cycle
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_INS_ORD = 3'd1,
    ACT_DEL_ORD = 3'd2,
    ACT_INS_UN  = 3'd3,
    ACT_DEL_UN  = 3'd4
  } act_t;

  typedef struct packed {
    status_t status;
    act_t    act;
    logic    rd_ok;   // successful read: return the selected entry
  } ctrl_t;

endpackage

@@ hw/rtl/aidp_cell.sv @@
// ----------------------------------------------------------------------------
// aidp_cell - one slot of the table
// Holds one word; takes it from the left or right neighbor, the new value,
// the moved entry or the last entry, depending on the action.
// ----------------------------------------------------------------------------
module aidp_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 3,
  parameter int CNT_W = 4
) (
  input  logic                               clk,
  input  aidp_pkg::act_t                     act,
  input  logic [IDX_W-1:0]                   idx,
  input  logic [CNT_W-1:0]                   cnt,
  input  logic signed [aidp_pkg::WORD_W-1:0] value,
  input  logic signed [aidp_pkg::WORD_W-1:0] left,
  input  logic signed [aidp_pkg::WORD_W-1:0] right,
  input  logic signed [aidp_pkg::WORD_W-1:0] moved,
  input  logic signed [aidp_pkg::WORD_W-1:0] last,
  output logic signed [aidp_pkg::WORD_W-1:0] q
);

  logic signed [aidp_pkg::WORD_W-1:0] q_next;
  logic at_idx, above_idx, upto_cnt, at_cnt, below_top;

  assign at_idx    = (IDX_W'(INDEX) == idx);
  assign above_idx = (IDX_W'(INDEX) > idx);
  assign upto_cnt  = (CNT_W'(INDEX) <= cnt);
  assign at_cnt    = (CNT_W'(INDEX) == cnt);
  // i + 1 < count
  assign below_top = ({1'b0, CNT_W'(INDEX)} + 1'b1) < {1'b0, cnt};

  always_comb begin
    q_next = q;
    case (act)
      aidp_pkg::ACT_INS_ORD: begin
        if (at_idx) q_next = value;
        else if (above_idx && upto_cnt) q_next = left;
      end
      aidp_pkg::ACT_INS_UN: begin
        if (at_idx) q_next = value;
        else if (at_cnt) q_next = moved;
      end
      aidp_pkg::ACT_DEL_ORD: begin
        if ((at_idx || above_idx) && below_top) q_next = right;
      end
      aidp_pkg::ACT_DEL_UN: begin
        if (at_idx) q_next = last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

@@ hw/rtl/aidp_ctrl.sv @@
// ----------------------------------------------------------------------------
// aidp_ctrl - operation decode and checks
// Full/empty and position checks, status, cell action and next count.
// ----------------------------------------------------------------------------
module aidp_ctrl #(
  parameter int CAPACITY = aidp_pkg::CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                         fire,
  input  logic [aidp_pkg::OP_W-1:0]    op,
  input  logic [aidp_pkg::POS_W-1:0]   position,
  input  logic [CNT_W-1:0]             cnt,
  output aidp_pkg::ctrl_t              ctrl,
  output logic [IDX_W-1:0]             idx,
  output logic [CNT_W-1:0]             cnt_next
);

  localparam int CMP_W = ((CNT_W > aidp_pkg::POS_W) ? CNT_W : aidp_pkg::POS_W) + 1;

  logic [CMP_W-1:0]              pos_w, cnt_w;
  logic [aidp_pkg::POS_W-1:0]    pos_m1;
  logic full, empty, ins_pos_ok, pos_ok;

  assign pos_w  = CMP_W'(position);
  assign cnt_w  = CMP_W'(cnt);
  assign pos_m1 = position - 1'b1;
  assign idx    = IDX_W'(pos_m1);

  assign full       = (cnt == CNT_W'(CAPACITY));
  assign empty      = (cnt == '0);
  assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + 1'b1);
  assign pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);

  always_comb begin
    ctrl.status = aidp_pkg::ST_BADPOS;
    ctrl.act    = aidp_pkg::ACT_NONE;
    ctrl.rd_ok  = 1'b0;
    cnt_next    = cnt;
    case (aidp_pkg::op_t'(op))
      aidp_pkg::OP_INS_ORD, aidp_pkg::OP_INS_UN: begin
        if (full) begin
          ctrl.status = aidp_pkg::ST_FULL;
        end else if (ins_pos_ok) begin
          ctrl.status = aidp_pkg::ST_OK;
          ctrl.act    = (aidp_pkg::op_t'(op) == aidp_pkg::OP_INS_ORD) ?
                        aidp_pkg::ACT_INS_ORD : aidp_pkg::ACT_INS_UN;
          cnt_next    = cnt + 1'b1;
        end
      end
      aidp_pkg::OP_DEL_ORD, aidp_pkg::OP_DEL_UN: begin
        if (empty) begin
          ctrl.status = aidp_pkg::ST_EMPTY;
        end else if (pos_ok) begin
          ctrl.status = aidp_pkg::ST_OK;
          ctrl.act    = (aidp_pkg::op_t'(op) == aidp_pkg::OP_DEL_ORD) ?
                        aidp_pkg::ACT_DEL_ORD : aidp_pkg::ACT_DEL_UN;
          cnt_next    = cnt - 1'b1;
        end
      end
      aidp_pkg::OP_READ: begin
        if (empty) begin
          ctrl.status = aidp_pkg::ST_EMPTY;
        end else if (pos_ok) begin
          ctrl.status = aidp_pkg::ST_OK;
          ctrl.rd_ok  = 1'b1;
        end
      end
      default: ;
    endcase
    // cells only move on an accepted item
    if (!fire) ctrl.act = aidp_pkg::ACT_NONE;
  end

endmodule

@@ hw/rtl/array_insert_delete_at_position.sv @@
// An accepted item's result is on the output register in the next cycle.
// Throughput: one item per cycle unless stalled; all cells update in the same
//   cycle and the count register follows, so each item sees the previous one.
// Input stall rises only while a result is held and the output side stalls.
// Reset clears the entry count and the output valid; table words are not
//   cleared and are only read once written.
// ----------------------------------------------------------------------------
// array_insert_delete_at_position - positional word table
// Row of CAPACITY cells with an occupancy count. Ordered and unordered
// insert/delete and read by one-based position, each with a status.
// ----------------------------------------------------------------------------
module array_insert_delete_at_position #(
  parameter int CAPACITY = aidp_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [aidp_pkg::OP_W-1:0]          op,
  input  logic [aidp_pkg::POS_W-1:0]         position,
  input  logic signed [aidp_pkg::WORD_W-1:0] value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic signed [aidp_pkg::WORD_W-1:0] read_value,
  output logic [aidp_pkg::OCC_W-1:0]         occupancy
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // entry count (valid entries are slots 0..count-1)
  logic [CNT_W-1:0] count, count_next;
  logic             in_fire;
  aidp_pkg::ctrl_t  ctrl;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last_idx;

  // cell outputs and the two broadcast buses
  logic signed [aidp_pkg::WORD_W-1:0] cell_q [CAPACITY];
  logic signed [aidp_pkg::WORD_W-1:0] sel_data;   // entry at the position
  logic signed [aidp_pkg::WORD_W-1:0] last_data;  // last valid entry

  // Output register frees up when it drains, so a new item can enter the
  // same cycle the old result leaves.
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  aidp_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .fire     (in_fire),
    .op       (op),
    .position (position),
    .cnt      (count),
    .ctrl     (ctrl),
    .idx      (idx),
    .cnt_next (count_next)
  );

  // count - 1 is only used by unordered delete, where count is non-zero
  assign last_idx  = IDX_W'(count - 1'b1);
  assign sel_data  = cell_q[idx];
  assign last_data = cell_q[last_idx];

  // Row of cells: each takes from its left neighbor on an ordered insert,
  // from its right neighbor on an ordered delete.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [aidp_pkg::WORD_W-1:0] left_in, right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_left
      assign left_in = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_right
      assign right_in = cell_q[i+1];
    end

    aidp_cell #(
      .INDEX (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk   (clk),
      .act   (ctrl.act),
      .idx   (idx),
      .cnt   (count),
      .value (value),
      .left  (left_in),
      .right (right_in),
      .moved (sel_data),
      .last  (last_data),
      .q     (cell_q[i])
    );
  end

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status     <= ctrl.status;
      read_value <= ctrl.rd_ok ? sel_data : '0;
      occupancy  <= aidp_pkg::OCC_W'(count_next);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_err_holds_count: assert property (@(posedge clk) disable iff (rst)
    in_fire && (ctrl.status != aidp_pkg::ST_OK) |=> $stable(count))
    else $error("count changed on a failed operation");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    in_fire && (ctrl.status == aidp_pkg::ST_OK) &&
    ((ctrl.act == aidp_pkg::ACT_INS_ORD) || (ctrl.act == aidp_pkg::ACT_INS_UN))
    |=> ({1'b0, count} == {1'b0, $past(count)} + 1'b1))
    else $error("insert did not grow the count by one");

  a_occ_matches: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (occupancy == aidp_pkg::OCC_W'(count)))
    else $error("reported occupancy differs from count");

  a_read_no_move: assert property (@(posedge clk) disable iff (rst)
    ctrl.rd_ok |-> (ctrl.act == aidp_pkg::ACT_NONE))
    else $error("read moved table entries");

endmodule

@@ dv/tb_array_insert_delete_at_position.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_insert_delete_at_position - testbench for the positional word table
// A short directed table covers empty, full and bad-position cases plus every
// op, then random fill/drain traffic runs against a scoreboard that tracks the
// table contents and count. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_array_insert_delete_at_position;

  localparam int CAP          = aidp_pkg::CAPACITY_DEF;
  localparam int OP_W         = aidp_pkg::OP_W;
  localparam int POS_W        = aidp_pkg::POS_W;
  localparam int WORD_W       = aidp_pkg::WORD_W;
  localparam int OCC_W        = aidp_pkg::OCC_W;
  localparam int RANDOM_ITEMS = 1175;

  // op codes the block must reject
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  // fixed receiver windows, in cycles after reset
  localparam int HOLD_START  = 300;
  localparam int HOLD_LEN    = 60;
  localparam int QUIET_START = 900;
  localparam int QUIET_LEN   = 300;

  typedef struct packed {
    aidp_pkg::status_t        st;
    logic signed [WORD_W-1:0] rd;
    logic [OCC_W-1:0]         occ;
  } table_result_t;

  // one directed row; known = 1 means the expected result is typed in here
  typedef struct packed {
    logic [OP_W-1:0]          opc;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] val;
    logic                     known;
    table_result_t            res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          op = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [WORD_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] read_value;
  logic [OCC_W-1:0]         occupancy;

  // scoreboard copy of the table
  logic signed [WORD_W-1:0] words_m [CAP];
  int unsigned              count_m = 0;
  bit                       filling = 1'b1;

  table_result_t pending_results [$];
  int            error_count = 0;
  int            items_sent = 0;
  int            status_tally [4] = '{0, 0, 0, 0};
  int            reads_returned = 0;
  int            peak_occupancy = 0;

  stim_row_t directed_rows [25];

  array_insert_delete_at_position dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .read_value (read_value),
    .occupancy  (occupancy)
  );

  always #5 clk = ~clk;

  // Scoreboard update: applies one accepted item to the table copy and
  // returns the result the block should report for it.
  task automatic apply_table_op(input logic [OP_W-1:0] opc, input logic [POS_W-1:0] pos,
                                input logic signed [WORD_W-1:0] val,
                                output table_result_t r);
    int idx;
    r.st = aidp_pkg::ST_OK;
    r.rd = '0;
    if (opc > aidp_pkg::OP_READ) begin
      r.st = aidp_pkg::ST_BADPOS;
    end else if (opc == aidp_pkg::OP_INS_ORD || opc == aidp_pkg::OP_INS_UN) begin
      // full test comes before the position test
      if (count_m >= CAP) begin
        r.st = aidp_pkg::ST_FULL;
      end else if (pos < 1 || pos > count_m + 1) begin
        r.st = aidp_pkg::ST_BADPOS;
      end else begin
        idx = pos - 1;
        if (opc == aidp_pkg::OP_INS_ORD) begin
          for (int i = int'(count_m); i > idx; i--) words_m[i] = words_m[i-1];
        end else begin
          // displaced entry goes to the end
          words_m[count_m] = words_m[idx];
        end
        words_m[idx] = val;
        count_m++;
      end
    end else if (count_m == 0) begin
      r.st = aidp_pkg::ST_EMPTY;
    end else if (pos < 1 || pos > count_m) begin
      r.st = aidp_pkg::ST_BADPOS;
    end else begin
      idx = pos - 1;
      case (opc)
        aidp_pkg::OP_READ: begin
          r.rd = words_m[idx];
        end
        aidp_pkg::OP_DEL_ORD: begin
          for (int i = idx; i + 1 < count_m; i++) words_m[i] = words_m[i+1];
          count_m--;
        end
        default: begin
          // hole is filled by the last entry
          words_m[idx] = words_m[count_m-1];
          count_m--;
        end
      endcase
    end
    r.occ = count_m[OCC_W-1:0];
  endtask

  // Present one item at the falling edge and hold it until accepted.
  // Random idle cycles come first unless the sender is in its quiet stretch.
  task automatic offer_item(input logic [OP_W-1:0] opc, input logic [POS_W-1:0] pos,
                            input logic signed [WORD_W-1:0] val, input bit quiet);
    while (!quiet && $urandom_range(99) < 24) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= opc;
    position <= pos;
    value    <= val;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    items_sent++;
  endtask

  // Random traffic: mostly legal ops that sweep the count between empty and
  // full, plus some reserved codes and out-of-range positions.
  task automatic pick_random_item(output logic [OP_W-1:0] opc, output logic [POS_W-1:0] pos,
                                  output logic signed [WORD_W-1:0] val);
    int unsigned roll;
    int unsigned kind;
    roll = $urandom_range(99);
    if (count_m == CAP) filling = 1'b0;
    else if (count_m == 0) filling = 1'b1;
    else if ($urandom_range(99) < 4) filling = !filling;

    val = $urandom;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0:       val = 32'sh7FFFFFFF;
        1:       val = 32'sh80000000;
        2:       val = 32'sh00000000;
        default: val = 32'shFFFFFFFF;
      endcase
    end

    if (roll < 8) begin
      opc = OP_W'($urandom_range(7));
      pos = POS_W'($urandom_range(15));
    end else begin
      kind = $urandom_range(99);
      if (kind < (filling ? 60 : 20)) begin
        opc = $urandom_range(1) ? aidp_pkg::OP_INS_ORD : aidp_pkg::OP_INS_UN;
        pos = POS_W'($urandom_range(count_m + 1, 1));
      end else begin
        if (kind < 80) opc = $urandom_range(1) ? aidp_pkg::OP_DEL_ORD : aidp_pkg::OP_DEL_UN;
        else opc = aidp_pkg::OP_READ;
        pos = POS_W'((count_m == 0) ? 1 : $urandom_range(count_m, 1));
      end
      // some positions pushed out of range
      if (roll < 14) begin
        case ($urandom_range(2))
          0:       pos = '0;
          1:       pos = POS_W'(count_m + 1);
          default: pos = POS_W'($urandom_range(15, 9));
        endcase
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off so the output register fills
  // and in_stall rises, then a stretch with no stalls at all.
  initial begin
    int cyc;
    cyc = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
        out_stall <= 1'b1;
      else if (cyc >= QUIET_START && cyc < QUIET_START + QUIET_LEN)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(99) < 24);
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    table_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d read_value %0d occupancy %0d",
               status, read_value, occupancy);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.st) begin
          $error("status: expected %0d, got %0d", exp_r.st, status);
          error_count++;
        end
        if (read_value !== exp_r.rd) begin
          $error("read_value: expected %0d, got %0d", exp_r.rd, read_value);
          error_count++;
        end
        if (occupancy !== exp_r.occ) begin
          $error("occupancy: expected %0d, got %0d", exp_r.occ, occupancy);
          error_count++;
        end
        status_tally[exp_r.st]++;
        if (exp_r.st == aidp_pkg::ST_OK && exp_r.rd != 0) reads_returned++;
        if (exp_r.occ > peak_occupancy) peak_occupancy = exp_r.occ;
      end
    end
  end

  // Main sequence
  initial begin
    table_result_t            predicted;
    logic [OP_W-1:0]          r_op;
    logic [POS_W-1:0]         r_pos;
    logic signed [WORD_W-1:0] r_val;

    for (int i = 0; i < CAP; i++) words_m[i] = '0;

    // op, position, value, known, {status, read_value, occupancy}
    directed_rows = '{
      // empty table: delete and read report empty even at a bad position
      '{aidp_pkg::OP_READ,    4'd1,  32'sd0,        1'b1, '{aidp_pkg::ST_EMPTY,  32'sd0, 4'd0}},
      '{aidp_pkg::OP_DEL_ORD, 4'd1,  32'sd0,        1'b1, '{aidp_pkg::ST_EMPTY,  32'sd0, 4'd0}},
      '{aidp_pkg::OP_DEL_UN,  4'd8,  32'sd0,        1'b1, '{aidp_pkg::ST_EMPTY,  32'sd0, 4'd0}},
      // insert past count+1, or at zero
      '{aidp_pkg::OP_INS_ORD, 4'd2,  32'sd5,        1'b1, '{aidp_pkg::ST_BADPOS, 32'sd0, 4'd0}},
      '{aidp_pkg::OP_INS_UN,  4'd0,  32'sd5,        1'b1, '{aidp_pkg::ST_BADPOS, 32'sd0, 4'd0}},
      // reserved codes
      '{OP_RSVD_5,            4'd1,  32'sd1,        1'b1, '{aidp_pkg::ST_BADPOS, 32'sd0, 4'd0}},
      '{OP_RSVD_6,            4'd8,  32'sh80000000, 1'b1, '{aidp_pkg::ST_BADPOS, 32'sd0, 4'd0}},
      '{OP_RSVD_7,            4'd15, 32'shFFFFFFFF, 1'b1, '{aidp_pkg::ST_BADPOS, 32'sd0, 4'd0}},
      // fill to capacity with both insert flavors, extremes of value
      '{aidp_pkg::OP_INS_ORD, 4'd1,  32'sh7FFFFFFF, 1'b1, '{aidp_pkg::ST_OK,     32'sd0, 4'd1}},
      '{aidp_pkg::OP_INS_ORD, 4'd1,  32'sh80000000, 1'b1, '{aidp_pkg::ST_OK,     32'sd0, 4'd2}},
      '{aidp_pkg::OP_INS_UN,  4'd1,  32'shFFFFFFFF, 1'b0, '{aidp_pkg::ST_OK,     32'sd0, 4'd0}},
      '{aidp_pkg::OP_INS_ORD, 4'd4,  32'sd0,        1'b0, '{aidp_pkg::ST_OK,     32'sd0, 4'd0}},
      '{aidp_pkg::OP_INS_UN,  4'd5,  32'sh5A5A5A5A, 1'b0, '{aidp_pkg::ST_OK,     32'sd0, 4'd0}},
      '{aidp_pkg::OP_INS_ORD, 4'd3,  32'sh12345678, 1'b0, '{aidp_pkg::ST_OK,     32'sd0, 4'd0}},
      '{aidp_pkg::OP_INS_UN,  4'd2,  32'shA5A5A5A5, 1'b0, '{aidp_pkg::ST_OK,     32'sd0, 4'd0}},
      '{aidp_pkg::OP_INS_ORD, 4'd8,  32'sh0F0F0F0F, 1'b0, '{aidp_pkg::ST_OK,     32'sd0, 4'd0}},
      // full wins over a bad position
      '{aidp_pkg::OP_INS_ORD, 4'd1,  32'sd7,        1'b1, '{aidp_pkg::ST_FULL,   32'sd0, 4'd8}},
      '{aidp_pkg::OP_INS_UN,  4'd9,  32'sd7,        1'b1, '{aidp_pkg::ST_FULL,   32'sd0, 4'd8}},
      '{aidp_pkg::OP_READ,    4'd8,  32'sd0,        1'b0, '{aidp_pkg::ST_OK,     32'sd0, 4'd0}},
      '{aidp_pkg::OP_READ,    4'd9,  32'sd0,        1'b1, '{aidp_pkg::ST_BADPOS, 32'sd0, 4'd8}},
      '{aidp_pkg::OP_READ,    4'd15, 32'sd0,        1'b1, '{aidp_pkg::ST_BADPOS, 32'sd0, 4'd8}},
      // deletes: middle, last slot, first slot
      '{aidp_pkg::OP_DEL_ORD, 4'd3,  32'sd0,        1'b0, '{aidp_pkg::ST_OK,     32'sd0, 4'd0}},
      '{aidp_pkg::OP_DEL_UN,  4'd7,  32'sd0,        1'b0, '{aidp_pkg::ST_OK,     32'sd0, 4'd0}},
      '{aidp_pkg::OP_DEL_UN,  4'd1,  32'sd0,        1'b0, '{aidp_pkg::ST_OK,     32'sd0, 4'd0}},
      '{aidp_pkg::OP_READ,    4'd0,  32'sd0,        1'b1, '{aidp_pkg::ST_BADPOS, 32'sd0, 4'd5}}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].opc, directed_rows[i].pos, directed_rows[i].val, 1'b0);
      apply_table_op(directed_rows[i].opc, directed_rows[i].pos, directed_rows[i].val,
                     predicted);
      pending_results.push_back(directed_rows[i].known ? directed_rows[i].res : predicted);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick_random_item(r_op, r_pos, r_val);
      offer_item(r_op, r_pos, r_val, n >= 400 && n < 600);
      apply_table_op(r_op, r_pos, r_val, predicted);
      pending_results.push_back(predicted);
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then keep watching to catch any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end

    $display("Covered %0d items: ok %0d, full %0d, empty %0d, bad position %0d",
             items_sent, status_tally[aidp_pkg::ST_OK], status_tally[aidp_pkg::ST_FULL],
             status_tally[aidp_pkg::ST_EMPTY], status_tally[aidp_pkg::ST_BADPOS]);
    $display("Nonzero reads returned %0d, peak occupancy %0d of %0d",
             reads_returned, peak_occupancy, CAP);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
